// ===== rtl/core/gcpu_pkg.sv =====
// Shared types and constants for the Gray-code phase unwrap block.
// No dependencies; imported by every module in rtl/core.
`timescale 1ns / 1ps

package gcpu_pkg;

    localparam int unsigned MAX_PATTERNS_DEF = 10;

    localparam int unsigned PIX_W      = 8;
    localparam int unsigned WPH_W      = 16;
    localparam int unsigned CODE_W     = 10;
    localparam int unsigned PHASE_W    = 26;
    localparam int unsigned IMG_W      = 8;
    localparam int unsigned NCODE_W    = 11;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 11;
    localparam int unsigned QUEUE_DEPTH = 2;

    // scaled numerator (unwrapped * 255) >> 16 fits in 18 bits
    localparam int unsigned NUM_W = 18;

    localparam logic [IMG_W-1:0] IMG_MAX = 8'd255;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_CODES     = 2'd2;

    // code_mode values
    localparam logic MODE_BINARY = 1'b0;
    localparam logic MODE_GRAY   = 1'b1;

    localparam logic [NCODE_W-1:0] NUM_CODES_RST = 11'd1024;

    typedef struct packed {
        logic                    pixel_valid;
        logic [PIX_W-1:0]        sample;
        logic [PIX_W-1:0]        reference;
        logic signed [WPH_W-1:0] wrapped_phase;
        logic                    last_pattern;
    } t_in_item;

    typedef struct packed {
        logic               code_valid;
        logic [CODE_W-1:0]  fringe_code;
        logic [PHASE_W-1:0] unwrapped_phase;
        logic [IMG_W-1:0]   image_value;
    } t_out_item;

    typedef struct packed {
        logic               code_mode;
        logic [PIX_W-1:0]   bit_threshold;
        logic [NCODE_W-1:0] num_codes;
    } t_cfg;

    // one finished pixel, handed from the decoder to the scaler
    typedef struct packed {
        logic               pixel_valid;
        logic [CODE_W-1:0]  code;
        logic [PHASE_W-1:0] unwrapped_phase;
    } t_job;

endpackage

// ===== rtl/core/gcpu_front.sv =====
// Pattern decoder: thresholds each beat, builds the fringe code, emits a job per pixel.
// Depends on gcpu_pkg.
`timescale 1ns / 1ps

module gcpu_front
    import gcpu_pkg::*;
#(
    parameter int unsigned MAX_PATTERNS = MAX_PATTERNS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cfg     i_cfg,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_in_item i_in,
    input  logic     i_full,
    output logic     o_push,
    output t_job     o_job
);

    localparam int unsigned IDX_W = $clog2(MAX_PATTERNS + 1);

    logic [CODE_W-1:0] r_acc, n_acc;
    logic              r_prev, n_prev;
    logic [IDX_W-1:0]  r_idx, n_idx;

    logic [PIX_W+1:0]  diff;
    logic              bit_one;
    logic              gbit;
    logic              accept;

    assign o_in_ready = !i_full;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        // sample - reference - threshold, sign bit clear means a one
        diff    = {2'b00, i_in.sample} - {2'b00, i_in.reference}
                - {2'b00, i_cfg.bit_threshold};
        bit_one = ~diff[PIX_W+1];
        gbit    = r_prev ^ bit_one;
        n_acc   = r_acc;
        n_prev  = r_prev;
        n_idx   = r_idx;
        if (32'(r_idx) < MAX_PATTERNS) begin
            if (i_cfg.code_mode == MODE_GRAY) begin
                n_prev = gbit;
                n_acc  = {r_acc[CODE_W-2:0], gbit};
            end else if (bit_one && (32'(r_idx) < CODE_W)) begin
                n_acc = r_acc | (CODE_W'(1) << r_idx);
            end
            n_idx = r_idx + IDX_W'(1);
        end
    end

    // adding half a turn is a sign-bit flip; low 16 bits of code<<16 are zero
    always_comb begin
        o_push                = accept && i_in.last_pattern;
        o_job.pixel_valid     = i_in.pixel_valid;
        o_job.code            = n_acc;
        o_job.unwrapped_phase = {n_acc, ~i_in.wrapped_phase[WPH_W-1],
                                 i_in.wrapped_phase[WPH_W-2:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_prev <= 1'b0;
            r_idx  <= '0;
        end else if (accept) begin
            if (i_in.last_pattern) begin
                r_acc  <= '0;
                r_prev <= 1'b0;
                r_idx  <= '0;
            end else begin
                r_acc  <= n_acc;
                r_prev <= n_prev;
                r_idx  <= n_idx;
            end
        end
    end

endmodule

// ===== rtl/core/gcpu_fifo.sv =====
// Short job queue between the pattern decoder and the scaler.
// Depends on gcpu_pkg (t_job, QUEUE_DEPTH).
`timescale 1ns / 1ps

module gcpu_fifo
    import gcpu_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_job o_job
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (32'(r_wr_ptr) == QUEUE_DEPTH - 1) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (32'(r_rd_ptr) == QUEUE_DEPTH - 1) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== rtl/core/gcpu_back.sv =====
// Scaler: image value = unwrapped * 255 / (num_codes * 65536), saturated,
// by one restoring step per cycle. Holds the output register. Depends on gcpu_pkg.
`timescale 1ns / 1ps

module gcpu_back
    import gcpu_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [NCODE_W-1:0] i_num_codes,
    input  logic               i_job_valid,
    output logic               o_job_ready,
    input  t_job               i_job,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_item          o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SAT,
        S_DIV,
        S_DONE
    } t_state;

    t_state             r_state, n_state;
    t_job               r_job, n_job;
    logic [NUM_W-1:0]   r_rem, n_rem;
    logic [NUM_W-1:0]   r_dsh, n_dsh;
    logic [IMG_W-1:0]   r_q, n_q;
    logic [2:0]         r_cnt, n_cnt;
    t_out_item          r_out, n_out;

    logic [NCODE_W-1:0] divisor;
    logic [PHASE_W+7:0] prod;
    logic               ge;
    logic [IMG_W-1:0]   q_next;

    assign divisor     = (i_num_codes == '0) ? NCODE_W'(1) : i_num_codes;
    assign o_job_ready = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_DONE);
    assign o_out       = r_out;

    function automatic t_out_item make_out(t_job job, logic [IMG_W-1:0] img);
        t_out_item res;
        res = '0;
        if (job.pixel_valid) begin
            res.code_valid      = 1'b1;
            res.fringe_code     = job.code;
            res.unwrapped_phase = job.unwrapped_phase;
            res.image_value     = img;
        end
        return res;
    endfunction

    always_comb begin
        // x*255 = (x << 8) - x
        prod    = {r_job.unwrapped_phase, 8'd0} - {8'd0, r_job.unwrapped_phase};
        ge      = (r_rem >= r_dsh);
        q_next  = {r_q[IMG_W-2:0], ge};
        n_state = r_state;
        n_job   = r_job;
        n_rem   = r_rem;
        n_dsh   = r_dsh;
        n_q     = r_q;
        n_cnt   = r_cnt;
        n_out   = r_out;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_job   = i_job;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_rem   = prod[PHASE_W+7:16];
                n_dsh   = {divisor, 7'd0};
                n_state = S_SAT;
            end
            S_SAT: begin
                if ({1'b0, r_rem} >= {divisor, 8'd0}) begin
                    n_out   = make_out(r_job, IMG_MAX);
                    n_state = S_DONE;
                end else begin
                    n_q     = '0;
                    n_cnt   = 3'd7;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem = ge ? (r_rem - r_dsh) : r_rem;
                n_dsh = r_dsh >> 1;
                n_q   = q_next;
                n_cnt = r_cnt - 3'd1;
                if (r_cnt == 3'd0) begin
                    n_out   = make_out(r_job, q_next);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_job <= n_job;
        r_rem <= n_rem;
        r_dsh <= n_dsh;
        r_q   <= n_q;
        r_cnt <= n_cnt;
        r_out <= n_out;
    end

endmodule

// ===== rtl/core/gray_code_phase_unwrap.sv =====
// Gray-code / binary temporal phase unwrap. Each input beat is one pattern
// sample of a pixel with its reference; the decoder thresholds it, folds the
// bit into the fringe code (Gray mode MSB first through a running XOR,
// binary mode LSB first by weight) and takes one beat per cycle while the
// queue has room. The beat marked last_pattern ends the pixel and queues one
// job in a two-entry queue; the scaler then forms unwrapped_phase =
// code*65536 + wrapped_phase + 32768 and image_value = unwrapped_phase*255 /
// (num_codes*65536), saturated at 255, and shows one result beat. The scaler
// works through each pixel in order (pop, multiply, saturation check, eight
// restoring divide steps unless saturated, output) and takes no new
// job until its result beat is taken. Invalid pixels give an all-zero
// result beat. The user must write configuration through a plain write
// port only while idle; the block itself does not enforce it.
// Depends on gcpu_pkg, gcpu_front, gcpu_fifo, gcpu_back.
`timescale 1ns / 1ps

module gray_code_phase_unwrap
    import gcpu_pkg::*;
#(
    parameter int unsigned MAX_PATTERNS = MAX_PATTERNS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // pattern beats in
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in,
    // result beats out
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out
);

    t_cfg r_cfg;

    logic push, q_full, q_valid, q_pop, back_ready;
    t_job push_job, q_job;

    // register writes keep only each register's width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.code_mode     <= MODE_GRAY;
            r_cfg.bit_threshold <= '0;
            r_cfg.num_codes     <= NUM_CODES_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                CFG_CODE_MODE:     r_cfg.code_mode     <= i_cfg_data[0];
                CFG_BIT_THRESHOLD: r_cfg.bit_threshold <= i_cfg_data[PIX_W-1:0];
                CFG_NUM_CODES:     r_cfg.num_codes     <= i_cfg_data[NCODE_W-1:0];
                default: ;
            endcase
        end
    end

    // front: per-beat decode, one beat a cycle while the queue has room
    gcpu_front #(
        .MAX_PATTERNS (MAX_PATTERNS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in       (i_in),
        .i_full     (q_full),
        .o_push     (push),
        .o_job      (push_job)
    );

    // queue decouples decoder from the scaler
    gcpu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_job   (q_job)
    );

    assign q_pop = q_valid && back_ready;

    // back: scaling divide and output register
    gcpu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_num_codes (r_cfg.num_codes),
        .i_job_valid (q_valid),
        .o_job_ready (back_ready),
        .i_job       (q_job),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

endmodule

// ===== rtl/core/gcpu_checker.sv =====
// Port-level checks for gray_code_phase_unwrap, attached by bind.
// Depends on gcpu_pkg.
`timescale 1ns / 1ps

module gcpu_checker
    import gcpu_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out))
        else $error("result beat changed while stalled");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.code_valid |->
            (o_out.fringe_code == '0) && (o_out.unwrapped_phase == '0)
            && (o_out.image_value == '0))
        else $error("invalid pixel with nonzero fields");

    a_phase_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.code_valid |->
            (o_out.unwrapped_phase[PHASE_W-1:16] == o_out.fringe_code))
        else $error("unwrapped phase integer part differs from fringe code");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("block not idle after reset");

endmodule

bind gray_code_phase_unwrap gcpu_checker u_gcpu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
